@@ src/apnv_pkg.sv @@
// package for the archive path name validator: constants, types and helpers
package apnv_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned DepthW     = 8;
  localparam int unsigned PosW       = 3;
  localparam int unsigned LeadN      = 4;

  localparam logic [DepthW-1:0] MaxDepthRst = 8'd24;
  localparam logic [DepthW-1:0] CountSat    = 8'd255;
  localparam logic [PosW-1:0]   PosSat      = 3'd7;

  localparam logic [CharW-1:0] ChNul       = 8'h00;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;
  localparam logic [CharW-1:0] ChCtrlLim   = 8'h20;
  localparam logic [CharW-1:0] ChQuote     = 8'h22;
  localparam logic [CharW-1:0] ChStar      = 8'h2a;
  localparam logic [CharW-1:0] ChDot       = 8'h2e;
  localparam logic [CharW-1:0] ChSlash     = 8'h2f;
  localparam logic [CharW-1:0] ChZero      = 8'h30;
  localparam logic [CharW-1:0] ChNine      = 8'h39;
  localparam logic [CharW-1:0] ChColon     = 8'h3a;
  localparam logic [CharW-1:0] ChLess      = 8'h3c;
  localparam logic [CharW-1:0] ChGreater   = 8'h3e;
  localparam logic [CharW-1:0] ChQuestion  = 8'h3f;
  localparam logic [CharW-1:0] ChBackslash = 8'h5c;
  localparam logic [CharW-1:0] ChLowA      = 8'h61;
  localparam logic [CharW-1:0] ChLowZ      = 8'h7a;
  localparam logic [CharW-1:0] ChPipe      = 8'h7c;
  localparam logic [CharW-1:0] CaseOffset  = 8'h20;

  localparam logic [23:0] NameCon = "CON";
  localparam logic [23:0] NamePrn = "PRN";
  localparam logic [23:0] NameAux = "AUX";
  localparam logic [23:0] NameNul = "NUL";
  localparam logic [23:0] NameCom = "COM";
  localparam logic [23:0] NameLpt = "LPT";

  typedef struct packed {
    logic [CharW-1:0] normalized_char;
    logic             path_end;
    logic             path_safe;
  } result_t;

  function automatic logic [CharW-1:0] to_upper(input logic [CharW-1:0] c);
    to_upper = (c >= ChLowA && c <= ChLowZ) ? c - CaseOffset : c;
  endfunction

  function automatic logic is_bad_char(input logic [CharW-1:0] c);
    is_bad_char = (c < ChCtrlLim) || (c == ChColon) || (c == ChStar) ||
                  (c == ChQuestion) || (c == ChQuote) || (c == ChLess) ||
                  (c == ChGreater) || (c == ChPipe);
  endfunction

endpackage

@@ src/apnv_check.sv @@
// per-path state and rule checks, one byte per cycle while accept is high
module apnv_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [apnv_pkg::CharW-1:0]  path_char,
  input  logic                        cfg_wr_en,
  input  logic [apnv_pkg::DepthW-1:0] cfg_wr_data,
  output apnv_pkg::result_t           result
);

  logic [apnv_pkg::DepthW-1:0] max_depth_r;
  logic                        path_start_r, path_start_nxt;
  logic                        comp_start_r, comp_start_nxt;
  logic [apnv_pkg::PosW-1:0]   pos_r, pos_nxt;
  logic [apnv_pkg::PosW-1:0]   stem_r, stem_nxt;
  logic                        dot_r, dot_nxt;
  logic [apnv_pkg::CharW-1:0]  lead_r [apnv_pkg::LeadN];
  logic [apnv_pkg::CharW-1:0]  lead_nxt [apnv_pkg::LeadN];
  logic                        final_bad_r, final_bad_nxt;
  logic [apnv_pkg::DepthW-1:0] count_r, count_nxt;
  logic                        rej_r, rej_nxt;

  logic [apnv_pkg::CharW-1:0]  n;
  logic [23:0]                 first3;
  logic                        digit4;
  logic                        reserved;
  logic                        comp_fail;
  logic                        end_rej;

  always_comb begin
    n = (path_char == apnv_pkg::ChBackslash) ? apnv_pkg::ChSlash : path_char;
    first3 = {apnv_pkg::to_upper(lead_r[0]), apnv_pkg::to_upper(lead_r[1]),
              apnv_pkg::to_upper(lead_r[2])};
    digit4 = (lead_r[3] >= apnv_pkg::ChZero) && (lead_r[3] <= apnv_pkg::ChNine);
    reserved = ((stem_r == 3'd3) &&
                ((first3 == apnv_pkg::NameCon) || (first3 == apnv_pkg::NamePrn) ||
                 (first3 == apnv_pkg::NameAux) || (first3 == apnv_pkg::NameNul))) ||
               ((stem_r == 3'd4) && digit4 &&
                ((first3 == apnv_pkg::NameCom) || (first3 == apnv_pkg::NameLpt)));
    comp_fail = final_bad_r || reserved;
    end_rej = rej_r || path_start_r || (!comp_start_r && comp_fail);
  end

  always_comb begin
    path_start_nxt = path_start_r;
    comp_start_nxt = comp_start_r;
    pos_nxt        = pos_r;
    stem_nxt       = stem_r;
    dot_nxt        = dot_r;
    lead_nxt       = lead_r;
    final_bad_nxt  = final_bad_r;
    count_nxt      = count_r;
    rej_nxt        = rej_r;

    result.normalized_char = n;
    result.path_end        = 1'b0;
    result.path_safe       = 1'b0;

    if (n == apnv_pkg::ChNul) begin
      result.path_end  = 1'b1;
      result.path_safe = !end_rej;
      path_start_nxt   = 1'b1;
      comp_start_nxt   = 1'b1;
      count_nxt        = '0;
      rej_nxt          = 1'b0;
      pos_nxt          = '0;
      stem_nxt         = '0;
      dot_nxt          = 1'b0;
      final_bad_nxt    = 1'b0;
      for (int i = 0; i < apnv_pkg::LeadN; i++) lead_nxt[i] = '0;
    end else if (n == apnv_pkg::ChSlash) begin
      path_start_nxt = 1'b0;
      if (path_start_r || comp_start_r) begin
        rej_nxt = 1'b1;
      end else begin
        rej_nxt        = rej_r || comp_fail;
        comp_start_nxt = 1'b1;
        pos_nxt        = '0;
        stem_nxt       = '0;
        dot_nxt        = 1'b0;
        final_bad_nxt  = 1'b0;
        for (int i = 0; i < apnv_pkg::LeadN; i++) lead_nxt[i] = '0;
      end
    end else begin
      path_start_nxt = 1'b0;
      if (comp_start_r) begin
        if (count_r >= max_depth_r) rej_nxt = 1'b1;
        if (count_r != apnv_pkg::CountSat) count_nxt = count_r + 1'b1;
        comp_start_nxt = 1'b0;
      end
      if (apnv_pkg::is_bad_char(n)) rej_nxt = 1'b1;
      if (pos_r < 3'd4) lead_nxt[pos_r[1:0]] = n;
      if (pos_r != apnv_pkg::PosSat) pos_nxt = pos_r + 1'b1;
      if (!dot_r) begin
        if (n == apnv_pkg::ChDot) begin
          dot_nxt = 1'b1;
        end else if (stem_r != apnv_pkg::PosSat) begin
          stem_nxt = stem_r + 1'b1;
        end
      end
      final_bad_nxt = (n == apnv_pkg::ChDot) || (n == apnv_pkg::ChSpace);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_depth_r <= apnv_pkg::MaxDepthRst;
    end else if (cfg_wr_en) begin
      max_depth_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_start_r <= 1'b1;
      comp_start_r <= 1'b1;
      pos_r        <= '0;
      stem_r       <= '0;
      dot_r        <= 1'b0;
      final_bad_r  <= 1'b0;
      count_r      <= '0;
      rej_r        <= 1'b0;
      for (int i = 0; i < apnv_pkg::LeadN; i++) lead_r[i] <= '0;
    end else if (accept) begin
      path_start_r <= path_start_nxt;
      comp_start_r <= comp_start_nxt;
      pos_r        <= pos_nxt;
      stem_r       <= stem_nxt;
      dot_r        <= dot_nxt;
      final_bad_r  <= final_bad_nxt;
      count_r      <= count_nxt;
      rej_r        <= rej_nxt;
      lead_r       <= lead_nxt;
    end
  end

endmodule

@@ src/archive_path_name_validator_top.sv @@
// top level of the archive path name validator with output register and skid beat
// the result of an accepted input beat is registered into the output register, or the skid register if stalled
// throughput: one beat per cycle while in_stall is low, with the check done combinationally per beat
// a skid register holds one extra accepted beat while the output is stalled
// reset: synchronous active-low rst_n clears path state and buffers, max_depth returns to 24
module archive_path_name_validator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [apnv_pkg::CharW-1:0]  in_path_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [apnv_pkg::CharW-1:0]  out_normalized_char,
  output logic                        out_path_end,
  output logic                        out_path_safe,
  input  logic                        cfg_wr_en,
  input  logic [apnv_pkg::DepthW-1:0] cfg_wr_data
);

  logic              in_acc;
  logic              out_take;
  apnv_pkg::result_t res;
  apnv_pkg::result_t out_r, skid_r;
  logic              out_valid_r, skid_valid_r;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  apnv_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .path_char   (in_path_char),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_valid_r && !out_take) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload moves with the valid flags above
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_r <= skid_r;
    end else if (in_acc) begin
      if (out_valid_r && !out_take) skid_r <= res;
      else                          out_r  <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_normalized_char = out_r.normalized_char;
  assign out_path_end        = out_r.path_end;
  assign out_path_safe       = out_r.path_safe;

endmodule
